FILE: rtl/bit_fifo_buffer_core_macros.svh
// assertion macros used by the bit fifo buffer pointer control
`ifndef BIT_FIFO_BUFFER_CORE_MACROS_SVH
`define BIT_FIFO_BUFFER_CORE_MACROS_SVH

// condition must hold in the same cycle
`define BFB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bfb assertion failed");

// condition must hold in the next cycle
`define BFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bfb assertion failed");

`endif

FILE: rtl/bfb_pkg.sv
// package with request codes, widths and the stage record of the bit fifo buffer
`timescale 1ns / 1ps
`default_nettype none

package bfb_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int REQ_W        = 3;
	localparam int BYTE_W       = 8;
	localparam int POS_W        = 3;
	localparam int CNT_W        = 14;

	typedef enum logic [REQ_W-1:0] {
		REQ_WR_BIT  = 3'd0,
		REQ_WR_BYTE = 3'd1,
		REQ_PAD     = 3'd2,
		REQ_RD_BIT  = 3'd3,
		REQ_RD_BYTE = 3'd4,
		REQ_REWIND  = 3'd5
	} req_t;

	// request outcome waiting for the store read data
	typedef struct packed {
		logic             ok;
		logic             rd_bit;
		logic             rd_byte;
		logic [POS_W-1:0] bit_sel;
		logic [CNT_W-1:0] bit_count;
		logic             aligned;
	} bfb_info_t;

endpackage

`default_nettype wire

FILE: rtl/bfb_if.sv
// request and response channel interfaces of the bit fifo buffer
`timescale 1ns / 1ps
`default_nettype none

interface bfb_req_if;
	import bfb_pkg::*;

	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic              bit_in;
	logic [BYTE_W-1:0] byte_in;

	modport source (output valid, req_type, bit_in, byte_in, input ready);
	modport sink   (input valid, req_type, bit_in, byte_in, output ready);
endinterface

interface bfb_rsp_if;
	import bfb_pkg::*;

	logic              valid;
	logic              ready;
	logic              ok;
	logic              bit_out;
	logic [BYTE_W-1:0] byte_out;
	logic [CNT_W-1:0]  bit_count;
	logic              write_aligned;

	modport source (output valid, ok, bit_out, byte_out, bit_count, write_aligned,
		input ready);
	modport sink   (input valid, ok, bit_out, byte_out, bit_count, write_aligned,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/bfb_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module bfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/bfb_ctrl.sv
// pointer control: decides each request, drives the byte store, holds stage one
`timescale 1ns / 1ps
`default_nettype none

`include "bit_fifo_buffer_core_macros.svh"

module bfb_ctrl #(
	parameter int CAPACITY = bfb_pkg::CAPACITY_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	bfb_req_if.sink                          req,
	output logic                             mem_we,
	output logic [$clog2(CAPACITY)-1:0]      mem_waddr,
	output logic [bfb_pkg::BYTE_W-1:0]       mem_wdata,
	output logic                             mem_re,
	output logic [$clog2(CAPACITY)-1:0]      mem_raddr,
	output logic                             s1_valid,
	output bfb_pkg::bfb_info_t               s1_info,
	input  wire logic                        s1_take
);
	import bfb_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY + 1);
	localparam int AW    = $clog2(CAPACITY);
	localparam int CW    = IDX_W + POS_W;
	localparam logic [IDX_W-1:0] CAP_IDX = IDX_W'(CAPACITY);

	logic [IDX_W-1:0]  wr_idx_q, wr_idx_n;
	logic [POS_W-1:0]  wr_pos_q, wr_pos_n;
	logic [IDX_W-1:0]  rd_idx_q, rd_idx_n;
	logic [POS_W-1:0]  rd_pos_q, rd_pos_n;
	logic [BYTE_W-1:0] partial_q, partial_n;
	logic              s1_v_q;
	bfb_info_t         info_s1;

	logic              fire;
	logic              full;
	logic              ok;
	logic              rd_bit;
	logic              rd_byte;
	logic [CW-1:0]     cnt_full;
	logic [CW+CNT_W-1:0] cnt_ext;

	assign req.ready = !s1_v_q || s1_take;
	assign fire      = req.valid && req.ready;
	assign full      = (wr_idx_q == CAP_IDX);

	always_comb begin
		wr_idx_n  = wr_idx_q;
		wr_pos_n  = wr_pos_q;
		rd_idx_n  = rd_idx_q;
		rd_pos_n  = rd_pos_q;
		partial_n = partial_q;
		ok        = 1'b0;
		rd_bit    = 1'b0;
		rd_byte   = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wdata = partial_q;
		case (req_t'(req.req_type))
			REQ_WR_BIT: begin
				if (!full) begin
					// bits above the write offset are always zero in the partial byte
					mem_wdata = partial_q | (BYTE_W'(req.bit_in) << wr_pos_q);
					mem_we    = fire;
					wr_pos_n  = wr_pos_q + POS_W'(1);
					ok        = 1'b1;
					if (wr_pos_q == '1) begin
						wr_idx_n  = wr_idx_q + IDX_W'(1);
						partial_n = '0;
					end else begin
						partial_n = mem_wdata;
					end
				end
			end
			REQ_WR_BYTE: begin
				if (wr_pos_q == '0 && !full) begin
					mem_wdata = req.byte_in;
					mem_we    = fire;
					wr_idx_n  = wr_idx_q + IDX_W'(1);
					ok        = 1'b1;
				end
			end
			REQ_PAD: begin
				ok = 1'b1;
				if (wr_pos_q != '0) begin
					mem_we    = fire;
					wr_idx_n  = wr_idx_q + IDX_W'(1);
					wr_pos_n  = '0;
					partial_n = '0;
				end
			end
			REQ_RD_BIT: begin
				if (rd_idx_q <= wr_idx_q && rd_idx_q != CAP_IDX &&
					!(rd_idx_q == wr_idx_q && rd_pos_q >= wr_pos_q)) begin
					mem_re   = fire;
					rd_pos_n = rd_pos_q + POS_W'(1);
					if (rd_pos_q == '1) begin
						rd_idx_n = rd_idx_q + IDX_W'(1);
					end
					ok     = 1'b1;
					rd_bit = 1'b1;
				end
			end
			REQ_RD_BYTE: begin
				if (rd_idx_q < wr_idx_q) begin
					mem_re   = fire;
					rd_idx_n = rd_idx_q + IDX_W'(1);
					ok       = 1'b1;
					rd_byte  = 1'b1;
				end
			end
			REQ_REWIND: begin
				rd_idx_n = '0;
				rd_pos_n = '0;
				ok       = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign mem_waddr = wr_idx_q[AW-1:0];
	assign mem_raddr = rd_idx_q[AW-1:0];

	// bit count wraps to the output width
	assign cnt_full = {wr_idx_n, wr_pos_n};
	assign cnt_ext  = (CW + CNT_W)'(cnt_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q  <= '0;
			wr_pos_q  <= '0;
			rd_idx_q  <= '0;
			rd_pos_q  <= '0;
			partial_q <= '0;
			s1_v_q    <= 1'b0;
		end else begin
			if (fire) begin
				wr_idx_q  <= wr_idx_n;
				wr_pos_q  <= wr_pos_n;
				rd_idx_q  <= rd_idx_n;
				rd_pos_q  <= rd_pos_n;
				partial_q <= partial_n;
				s1_v_q    <= 1'b1;
			end else if (s1_take) begin
				s1_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			info_s1.ok        <= ok;
			info_s1.rd_bit    <= rd_bit;
			info_s1.rd_byte   <= rd_byte;
			info_s1.bit_sel   <= rd_pos_q;
			info_s1.bit_count <= cnt_ext[CNT_W-1:0];
			info_s1.aligned   <= (wr_pos_n == '0);
		end
	end

	assign s1_valid = s1_v_q;
	assign s1_info  = info_s1;

	`BFB_ASSERT_NOW(a_rd_behind_wr, clk, arst_n, 1'b1, rd_idx_q <= wr_idx_q)
	`BFB_ASSERT_NOW(a_offset_not_full, clk, arst_n, wr_pos_q != '0, wr_idx_q < CAP_IDX)
	`BFB_ASSERT_NOW(a_partial_clean, clk, arst_n, 1'b1, (partial_q >> wr_pos_q) == '0)
	`BFB_ASSERT_NEXT(a_rewind_clears, clk, arst_n,
		fire && req.req_type == REQ_REWIND, rd_idx_q == '0 && rd_pos_q == '0)

endmodule

`default_nettype wire

FILE: rtl/bfb_resp.sv
// response stage: picks the read bit or byte and holds the result for transfer
`timescale 1ns / 1ps
`default_nettype none

module bfb_resp (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s1_valid,
	input  bfb_pkg::bfb_info_t         s1_info,
	input  wire logic [bfb_pkg::BYTE_W-1:0] rdata,
	output logic                       s1_take,
	bfb_rsp_if.source                  rsp
);
	import bfb_pkg::*;

	logic              out_v_q;
	logic              ok_q;
	logic              bit_q;
	logic [BYTE_W-1:0] byte_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              aligned_q;

	assign s1_take = s1_valid && (!out_v_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_take) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			ok_q      <= s1_info.ok;
			bit_q     <= s1_info.rd_bit && rdata[s1_info.bit_sel];
			byte_q    <= s1_info.rd_byte ? rdata : '0;
			cnt_q     <= s1_info.bit_count;
			aligned_q <= s1_info.aligned;
		end
	end

	assign rsp.valid         = out_v_q;
	assign rsp.ok            = ok_q;
	assign rsp.bit_out       = bit_q;
	assign rsp.byte_out      = byte_q;
	assign rsp.bit_count     = cnt_q;
	assign rsp.write_aligned = aligned_q;

endmodule

`default_nettype wire

FILE: rtl/bit_fifo_buffer_core.sv
// top level of the lsb first bit stream buffer
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    req_type, bit_in, byte_in
//  rsp      out  valid/ready    ok, bit_out, byte_out, bit_count, write_aligned
//
// one request per cycle while rsp is not stalled; a result is held in stage one
// with the registered read port of the byte store, then in the output register
// reset zeroes both pointers; the store is not cleared and needs no sweep
// a stalled rsp holds the result and stops req once the stage behind it is full
`timescale 1ns / 1ps
`default_nettype none

module bit_fifo_buffer_core #(
	parameter int CAPACITY = bfb_pkg::CAPACITY_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bfb_req_if.sink    req,
	bfb_rsp_if.source  rsp
);
	import bfb_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [BYTE_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [BYTE_W-1:0] mem_rdata;
	logic              s1_valid;
	logic              s1_take;
	bfb_info_t         s1_info;

	bfb_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.s1_valid  (s1_valid),
		.s1_info   (s1_info),
		.s1_take   (s1_take)
	);

	bfb_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	bfb_resp u_resp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid),
		.s1_info  (s1_info),
		.rdata    (mem_rdata),
		.s1_take  (s1_take),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// testbench for the bit fifo buffer core: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module tb_top;
	import bfb_pkg::*;

	localparam int STORE_BYTES = CAPACITY_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 8;
	// request codes the block ignores
	localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

	typedef struct packed {
		logic              ok;
		logic              bit_out;
		logic [BYTE_W-1:0] byte_out;
		logic [CNT_W-1:0]  bit_count;
		logic              aligned;
	} rsp_rec_t;

	logic clk = 1'b0;
	logic arst_n;

	bfb_req_if req_ch ();
	bfb_rsp_if rsp_ch ();

	bit_fifo_buffer_core #(
		.CAPACITY(STORE_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	// shadow of the bit stream and both pointers
	logic [BYTE_W-1:0] stream_mem [STORE_BYTES];
	logic [10:0]       wr_idx = '0;
	logic [POS_W-1:0]  wr_pos = '0;
	logic [10:0]       rd_idx = '0;
	logic [POS_W-1:0]  rd_pos = '0;

	rsp_rec_t    pending_rsp [$];
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	bit          gap_enable = 1'b0;
	bit          stall_enable = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void append_bit(input logic b);
		stream_mem[wr_idx][wr_pos] = b;
		wr_pos = wr_pos + 3'd1;
		if (wr_pos == 3'd0)
			wr_idx = wr_idx + 11'd1;
	endfunction

	function automatic rsp_rec_t predict_request(input logic [REQ_W-1:0] kind, input logic b,
			input logic [BYTE_W-1:0] by);
		rsp_rec_t r;
		r = '0;
		case (kind)
			REQ_WR_BIT: begin
				if (wr_idx < STORE_BYTES) begin
					append_bit(b);
					r.ok = 1'b1;
				end
			end
			REQ_WR_BYTE: begin
				if (wr_pos == 3'd0 && wr_idx < STORE_BYTES) begin
					stream_mem[wr_idx] = by;
					wr_idx = wr_idx + 11'd1;
					r.ok = 1'b1;
				end
			end
			REQ_PAD: begin
				while (wr_pos != 3'd0 && wr_idx < STORE_BYTES)
					append_bit(1'b0);
				r.ok = 1'b1;
			end
			REQ_RD_BIT: begin
				// stops at the write pointer, bit by bit
				if (rd_idx <= wr_idx && rd_idx < STORE_BYTES &&
						!(rd_idx == wr_idx && rd_pos >= wr_pos)) begin
					r.bit_out = stream_mem[rd_idx][rd_pos];
					rd_pos = rd_pos + 3'd1;
					if (rd_pos == 3'd0)
						rd_idx = rd_idx + 11'd1;
					r.ok = 1'b1;
				end
			end
			REQ_RD_BYTE: begin
				// whole byte at the read index, bit offset left alone
				if (rd_idx < wr_idx && rd_idx < STORE_BYTES) begin
					r.byte_out = stream_mem[rd_idx];
					rd_idx = rd_idx + 11'd1;
					r.ok = 1'b1;
				end
			end
			REQ_REWIND: begin
				rd_idx = '0;
				rd_pos = '0;
				r.ok = 1'b1;
			end
			default: begin
			end
		endcase
		r.bit_count = {wr_idx, wr_pos};
		r.aligned = (wr_pos == 3'd0);
		return r;
	endfunction

	function automatic logic [REQ_W-1:0] draw_request(input int unsigned w_wbit, w_wbyte,
			w_pad, w_rbit, w_rbyte, w_rew);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < w_wbit) return REQ_WR_BIT;
		pick -= w_wbit;
		if (pick < w_wbyte) return REQ_WR_BYTE;
		pick -= w_wbyte;
		if (pick < w_pad) return REQ_PAD;
		pick -= w_pad;
		if (pick < w_rbit) return REQ_RD_BIT;
		pick -= w_rbit;
		if (pick < w_rbyte) return REQ_RD_BYTE;
		pick -= w_rbyte;
		if (pick < w_rew) return REQ_REWIND;
		return ($urandom_range(0, 1) != 0) ? REQ_SPARE_B : REQ_SPARE_A;
	endfunction

	// drives one request and records its expected result at the transfer
	task automatic issue_request(input logic [REQ_W-1:0] kind, input logic b,
			input logic [BYTE_W-1:0] by);
		if (gap_enable && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.bit_in <= b;
		req_ch.byte_in <= by;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_rsp.push_back(predict_request(kind, b, by));
	endtask

	task automatic issue_random(input logic [REQ_W-1:0] kind);
		issue_request(kind, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
	endtask

	task automatic wait_results_drained();
		req_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic test_directed_cases();
		gap_enable = 1'b1;
		stall_enable = 1'b1;
		issue_request(REQ_RD_BIT, 1'b0, 8'h00);   // nothing written yet
		issue_request(REQ_RD_BYTE, 1'b1, 8'hFF);
		issue_request(REQ_PAD, 1'b1, 8'hFF);      // already aligned
		issue_request(REQ_WR_BIT, 1'b1, 8'h00);
		issue_request(REQ_WR_BYTE, 1'b0, 8'hA5);  // refused, not aligned
		issue_request(REQ_RD_BYTE, 1'b0, 8'h00);  // no whole byte yet
		issue_request(REQ_RD_BIT, 1'b0, 8'h00);
		issue_request(REQ_RD_BIT, 1'b1, 8'hFF);   // read pointer at write pointer
		issue_request(REQ_WR_BIT, 1'b0, 8'hFF);
		issue_request(REQ_WR_BIT, 1'b1, 8'h00);
		issue_request(REQ_PAD, 1'b0, 8'h00);
		issue_request(REQ_WR_BYTE, 1'b0, 8'hFF);
		issue_request(REQ_WR_BYTE, 1'b1, 8'h00);
		issue_request(REQ_RD_BYTE, 1'b0, 8'h00);  // bit offset nonzero here
		issue_request(REQ_RD_BIT, 1'b0, 8'h00);
		issue_request(REQ_REWIND, 1'b1, 8'hFF);
		issue_request(REQ_RD_BYTE, 1'b0, 8'h00);
		issue_request(REQ_SPARE_A, 1'b1, 8'hFF);
		issue_request(REQ_SPARE_B, 1'b0, 8'h00);
		issue_request(REQ_WR_BIT, 1'b0, 8'h5A);
	endtask

	task automatic test_random_mix();
		for (int n = 0; n < 650; n++) begin
			// switch idling on and off in stretches
			if (n % 64 == 0) begin
				gap_enable = ($urandom_range(0, 3) != 0);
				stall_enable = ($urandom_range(0, 3) != 0);
			end
			issue_random(draw_request(25, 15, 8, 22, 18, 7));
		end
	endtask

	// mostly byte writes so the store fills in about one request per byte
	task automatic test_fill_to_capacity();
		gap_enable = 1'b1;
		stall_enable = 1'b1;
		while (wr_idx < STORE_BYTES)
			issue_random(draw_request(0, 94, 4, 0, 2, 0));
	endtask

	task automatic test_full_store();
		gap_enable = 1'b0;
		stall_enable = 1'b0;
		for (int n = 0; n < 160; n++)
			issue_random(draw_request(20, 20, 10, 20, 15, 10));
	endtask

	// result side stalls in bursts
	initial begin
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (stall_enable && $urandom_range(0, 7) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	function automatic int unsigned field_bad(input string name, input logic [CNT_W-1:0] want,
			input logic [CNT_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk) begin : check_rsp
		rsp_rec_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				$error("result transfer with no request outstanding");
				fail_count++;
			end else begin
				want = pending_rsp.pop_front();
				fail_count += field_bad("ok", CNT_W'(want.ok), CNT_W'(rsp_ch.ok));
				fail_count += field_bad("bit_out", CNT_W'(want.bit_out),
					CNT_W'(rsp_ch.bit_out));
				fail_count += field_bad("byte_out", CNT_W'(want.byte_out),
					CNT_W'(rsp_ch.byte_out));
				fail_count += field_bad("bit_count", want.bit_count, rsp_ch.bit_count);
				fail_count += field_bad("write_aligned", CNT_W'(want.aligned),
					CNT_W'(rsp_ch.write_aligned));
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : run_tests
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_WR_BIT;
		req_ch.bit_in <= 1'b0;
		req_ch.byte_in <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		wait_results_drained();
		test_random_mix();
		wait_results_drained();
		test_fill_to_capacity();
		test_full_store();
		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
